// File: sv/hds_pkg.sv
// shared constants, payload types and register codes for the heat diffusion stencil
`default_nettype none

package hds_pkg;

  // grid geometry: interior side plus a one-cell border ring on each side
  localparam int GRID_SIDE  = 256;
  localparam int ROW_LEN    = GRID_SIDE + 2;
  localparam int IDX_W      = $clog2(ROW_LEN);
  localparam int CELL_IDX_W = 9;

  // field widths
  localparam int TEMP_W = 32;
  localparam int SRC_W  = 16;
  localparam int GAIN_W = 24;
  localparam int RES_W  = 64;
  localparam int LAP_W  = TEMP_W + 4;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // result queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // configuration port
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CONDUCTION = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SOURCE     = REG_IDX_W'(1);

  localparam logic [GAIN_W-1:0] CONDUCTION_RESET = GAIN_W'(1629653);
  localparam logic [GAIN_W-1:0] SOURCE_RESET     = GAIN_W'(450640);

  typedef struct packed {
    logic [TEMP_W-1:0] cell_temperature;
    logic [SRC_W-1:0]  heat_source;
    logic              hold_cell;
  } cell_t;

  typedef struct packed {
    logic [TEMP_W-1:0]        new_temperature;
    logic signed [TEMP_W-1:0] temperature_change;
    logic [CELL_IDX_W-1:0]    cell_row;
    logic [CELL_IDX_W-1:0]    cell_column;
    logic                     sweep_done;
    logic [RES_W-1:0]         residual_squares;
  } result_t;

  // five-point window of one interior centre, plus bookkeeping
  typedef struct packed {
    logic [TEMP_W-1:0]     up;
    logic [TEMP_W-1:0]     down;
    logic [TEMP_W-1:0]     left;
    logic [TEMP_W-1:0]     right;
    logic [TEMP_W-1:0]     centre;
    logic [SRC_W-1:0]      src;
    logic                  hold;
    logic [CELL_IDX_W-1:0] row;
    logic [CELL_IDX_W-1:0] col;
    logic                  first;
    logic                  done;
  } window_t;

  typedef struct packed {
    logic [GAIN_W-1:0] conduction_gain;
    logic [GAIN_W-1:0] source_gain;
  } gains_t;

endpackage

`default_nettype wire

// File: sv/hds_ram.sv
// generic single write port ram with registered read
`default_nettype none

module hds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/hds_front.sv
// front end: raster counters, line stores and five-point window assembly
`default_nettype none

module hds_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire hds_pkg::cell_t              grid_cell,
  output logic                             full,
  input  wire logic [hds_pkg::Q_CNT_W-1:0] q_count,
  output logic                             q_push,
  output hds_pkg::window_t                 q_data
);

  localparam int IW = hds_pkg::IDX_W;

  logic [IW-1:0] col;
  logic [IW-1:0] row;
  logic          accept;
  logic [IW-1:0] mid_raddr;

  logic                  s1_valid;
  hds_pkg::cell_t        s1_cell;
  logic [IW-1:0]         s1_col;
  logic [IW-1:0]         s1_row;

  hds_pkg::cell_t              mid_rd;
  logic [hds_pkg::TEMP_W-1:0]  up_rd;

  // window taps of the previous columns
  logic [hds_pkg::TEMP_W-1:0] p_mid;
  logic [hds_pkg::SRC_W-1:0]  p_src;
  logic                       p_hold;
  logic [hds_pkg::TEMP_W-1:0] pp_mid;

  logic [hds_pkg::Q_CNT_W:0] pending;
  logic [IW-1:0]             row_m1;

  assign pending = {1'b0, q_count} + {{hds_pkg::Q_CNT_W{1'b0}}, s1_valid};
  assign full    = rst || (pending >= (hds_pkg::Q_CNT_W + 1)'(hds_pkg::Q_DEPTH));
  assign accept  = push && !full;

  // middle line is read one column ahead, wrapping to column zero on the last column
  assign mid_raddr = (col == IW'(hds_pkg::ROW_LEN - 1)) ? '0 : col + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == IW'(hds_pkg::ROW_LEN - 1)) begin
        col <= '0;
        if (row == IW'(hds_pkg::ROW_LEN - 1)) begin
          row <= '0;
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell <= grid_cell;
      s1_col  <= col;
      s1_row  <= row;
    end
    if (s1_valid) begin
      p_mid  <= mid_rd.cell_temperature;
      p_src  <= mid_rd.heat_source;
      p_hold <= mid_rd.hold_cell;
      pp_mid <= p_mid;
    end
  end

  // middle line: previous row's temperature, source and hold flag
  hds_ram #(
    .WIDTH($bits(hds_pkg::cell_t)),
    .DEPTH(hds_pkg::ROW_LEN)
  ) u_mid_line (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col),
    .wdata(s1_cell),
    .re   (accept),
    .raddr(mid_raddr),
    .rdata(mid_rd)
  );

  // upper line: temperature two rows back, fed from the centre tap
  hds_ram #(
    .WIDTH(hds_pkg::TEMP_W),
    .DEPTH(hds_pkg::ROW_LEN)
  ) u_up_line (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col),
    .wdata(p_mid),
    .re   (accept),
    .raddr(col),
    .rdata(up_rd)
  );

  assign row_m1 = s1_row - 1'b1;

  // centre is the cell just above; right neighbour is the word read one column ahead
  assign q_push = s1_valid && (s1_row >= IW'(2)) && (s1_col >= IW'(1))
               && (s1_col <= IW'(hds_pkg::GRID_SIDE));

  always_comb begin
    q_data.up     = up_rd;
    q_data.down   = s1_cell.cell_temperature;
    q_data.left   = pp_mid;
    q_data.right  = mid_rd.cell_temperature;
    q_data.centre = p_mid;
    q_data.src    = p_src;
    q_data.hold   = p_hold;
    q_data.row    = hds_pkg::CELL_IDX_W'(row_m1);
    q_data.col    = hds_pkg::CELL_IDX_W'(s1_col);
    q_data.first  = (s1_row == IW'(2)) && (s1_col == IW'(1));
    q_data.done   = (s1_row == IW'(hds_pkg::GRID_SIDE + 1))
                 && (s1_col == IW'(hds_pkg::GRID_SIDE));
  end

endmodule

`default_nettype wire

// File: sv/hds_queue.sv
// short window queue between front and back
`default_nettype none

module hds_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr,
  input  wire hds_pkg::window_t            wdata,
  input  wire logic                        rd,
  output hds_pkg::window_t                 head,
  output logic                             q_empty,
  output logic [hds_pkg::Q_CNT_W-1:0]      count
);

  hds_pkg::window_t             mem [hds_pkg::Q_DEPTH];
  logic [hds_pkg::Q_PTR_W-1:0]  wptr;
  logic [hds_pkg::Q_PTR_W-1:0]  rptr;

  assign q_empty = (count == '0);
  assign head    = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      priority if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end else begin
        count <= count;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/hds_back.sv
// back end: stencil arithmetic pipeline, residual sum and result queue
`default_nettype none

module hds_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire hds_pkg::gains_t     gains,
  input  wire hds_pkg::window_t    q_head,
  input  wire logic                q_empty,
  output logic                     q_pop,
  input  wire logic                pop,
  output logic                     empty,
  output hds_pkg::result_t         result
);

  localparam int TW      = hds_pkg::TEMP_W;
  localparam int LW      = hds_pkg::LAP_W;
  localparam int PROD_W  = LW + hds_pkg::GAIN_W + 1;
  localparam int PS_W    = hds_pkg::GAIN_W + hds_pkg::SRC_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int DELTA_W = SUM_W - 24;
  localparam int NT_W    = DELTA_W + 1;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << 23);

  typedef struct packed {
    logic [hds_pkg::CELL_IDX_W-1:0] row;
    logic [hds_pkg::CELL_IDX_W-1:0] col;
    logic                           first;
    logic                           done;
  } meta_t;

  // stage 1: laplacian
  logic                       s1_valid;
  logic signed [LW-1:0]       s1_lap;
  logic [hds_pkg::SRC_W-1:0]  s1_src;
  logic [TW-1:0]              s1_centre;
  logic                       s1_hold;
  meta_t                      s1_meta;
  // stage 2: products
  logic                       s2_valid;
  logic signed [PROD_W-1:0]   s2_prod_c;
  logic [PS_W-1:0]            s2_prod_s;
  logic [TW-1:0]              s2_centre;
  logic                       s2_hold;
  meta_t                      s2_meta;
  // stage 3: delta and new temperature
  logic                       s3_valid;
  logic [TW-1:0]              s3_sd;
  logic [TW-1:0]              s3_nt;
  meta_t                      s3_meta;
  // stage 4: squared delta
  logic                       s4_valid;
  logic [hds_pkg::RES_W-1:0]  s4_sq;
  logic [TW-1:0]              s4_sd;
  logic [TW-1:0]              s4_nt;
  meta_t                      s4_meta;

  logic [hds_pkg::RES_W-1:0]  resid;
  logic [hds_pkg::RES_W-1:0]  resid_next;
  logic [hds_pkg::RES_W-1:0]  resid_base;
  logic [hds_pkg::RES_W:0]    resid_sum;

  logic [LW-2:0]              nb_sum;
  logic signed [LW-1:0]       lap;
  logic signed [SUM_W-1:0]    acc_sum;
  logic signed [DELTA_W-1:0]  delta;
  logic signed [NT_W-1:0]     nt_sum;
  logic [TW-1:0]              sd_sat;
  logic [TW-1:0]              nt_sat;
  logic [TW-1:0]              mag;

  hds_pkg::result_t               out_mem [hds_pkg::OUT_DEPTH];
  logic [hds_pkg::OUT_PTR_W-1:0]  out_wptr;
  logic [hds_pkg::OUT_PTR_W-1:0]  out_rptr;
  logic [hds_pkg::OUT_CNT_W-1:0]  out_count;
  logic [hds_pkg::OUT_CNT_W:0]    committed;
  logic                           out_rd;
  hds_pkg::result_t               out_entry;

  // credit: room in the result queue for everything already in flight
  assign committed = {1'b0, out_count}
                   + (hds_pkg::OUT_CNT_W + 1)'(s1_valid) + (hds_pkg::OUT_CNT_W + 1)'(s2_valid)
                   + (hds_pkg::OUT_CNT_W + 1)'(s3_valid) + (hds_pkg::OUT_CNT_W + 1)'(s4_valid);
  assign q_pop = !q_empty && (committed < (hds_pkg::OUT_CNT_W + 1)'(hds_pkg::OUT_DEPTH));

  always_comb begin
    nb_sum = (LW - 1)'(q_head.up) + (LW - 1)'(q_head.down)
           + (LW - 1)'(q_head.left) + (LW - 1)'(q_head.right);
    lap    = $signed({1'b0, nb_sum}) - $signed({2'b00, q_head.centre, 2'b00});
  end

  always_comb begin
    acc_sum = SUM_W'(s2_prod_c)
            + $signed({{(SUM_W - PS_W - 6){1'b0}}, s2_prod_s, 6'b0})
            + ROUND_HALF;
    delta   = acc_sum[SUM_W-1:24];
    if ((delta[DELTA_W-1:TW-1] == '0) || (delta[DELTA_W-1:TW-1] == '1)) begin
      sd_sat = delta[TW-1:0];
    end else if (delta[DELTA_W-1]) begin
      sd_sat = {1'b1, {(TW - 1){1'b0}}};
    end else begin
      sd_sat = {1'b0, {(TW - 1){1'b1}}};
    end
    nt_sum = $signed({{(NT_W - TW){1'b0}}, s2_centre}) + NT_W'(delta);
    if (s2_hold) begin
      nt_sat = s2_centre;
    end else if (nt_sum[NT_W-1]) begin
      nt_sat = '0;
    end else if (|nt_sum[NT_W-2:TW]) begin
      nt_sat = '1;
    end else begin
      nt_sat = nt_sum[TW-1:0];
    end
  end

  assign mag = s3_sd[TW-1] ? (~s3_sd + 1'b1) : s3_sd;

  always_comb begin
    resid_base = s4_meta.first ? '0 : resid;
    resid_sum  = {1'b0, resid_base} + {1'b0, s4_sq};
    resid_next = resid_sum[hds_pkg::RES_W] ? '1 : resid_sum[hds_pkg::RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      resid    <= '0;
    end else begin
      s1_valid <= q_pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      if (s4_valid) begin
        resid <= resid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_lap         <= lap;
    s1_src         <= q_head.src;
    s1_centre      <= q_head.centre;
    s1_hold        <= q_head.hold;
    s1_meta.row    <= q_head.row;
    s1_meta.col    <= q_head.col;
    s1_meta.first  <= q_head.first;
    s1_meta.done   <= q_head.done;

    s2_prod_c <= s1_lap * $signed({1'b0, gains.conduction_gain});
    s2_prod_s <= s1_src * gains.source_gain;
    s2_centre <= s1_centre;
    s2_hold   <= s1_hold;
    s2_meta   <= s1_meta;

    s3_sd   <= sd_sat;
    s3_nt   <= nt_sat;
    s3_meta <= s2_meta;

    s4_sq   <= mag * mag;
    s4_sd   <= s3_sd;
    s4_nt   <= s3_nt;
    s4_meta <= s3_meta;
  end

  // result queue
  always_comb begin
    out_entry.new_temperature    = s4_nt;
    out_entry.temperature_change = s4_sd;
    out_entry.cell_row           = s4_meta.row;
    out_entry.cell_column        = s4_meta.col;
    out_entry.sweep_done         = s4_meta.done;
    out_entry.residual_squares   = resid_next;
  end

  assign empty  = rst || (out_count == '0);
  assign out_rd = pop && !empty;
  assign result = out_mem[out_rptr];

  always_ff @(posedge clk) begin
    if (s4_valid) begin
      out_mem[out_wptr] <= out_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wptr  <= '0;
      out_rptr  <= '0;
      out_count <= '0;
    end else begin
      if (s4_valid) begin
        out_wptr <= out_wptr + 1'b1;
      end
      if (out_rd) begin
        out_rptr <= out_rptr + 1'b1;
      end
      priority if (s4_valid && !out_rd) begin
        out_count <= out_count + 1'b1;
      end else if (out_rd && !s4_valid) begin
        out_count <= out_count - 1'b1;
      end else begin
        out_count <= out_count;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/heat_diffusion_stencil_step.sv
// top level of the five-point heat diffusion stencil engine
// throughput: one cell request per clock, sustained while results are popped
// path: the cell below a centre passes the line-store read, the window queue (held back
//   when the result queue has no credit), 4 arithmetic stages and the result queue
// border cells are absorbed and produce no result
// reset: synchronous, clears counters, queues and residual sum and reloads the gains;
//   line stores are not cleared, no clearing pass is needed
`default_nettype none

module heat_diffusion_stencil_step (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // cell requests, raster order including the border ring
  input  wire logic                         push,
  input  wire hds_pkg::cell_t               grid_cell,
  output logic                              full,
  // result requests, one per interior cell
  output logic                              empty,
  input  wire logic                         pop,
  output hds_pkg::result_t                  result,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [hds_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [hds_pkg::DATA_W-1:0]   pwdata,
  output logic      [hds_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  // gain registers
  hds_pkg::gains_t                    gains;
  logic                               cfg_wr;
  logic [hds_pkg::REG_IDX_W-1:0]      reg_idx;

  // front to queue
  logic                               q_push;
  hds_pkg::window_t                   q_data;
  logic [hds_pkg::Q_CNT_W-1:0]        q_count;

  // queue to back
  hds_pkg::window_t                   q_head;
  logic                               q_empty;
  logic                               q_pop;

  // zero wait state port, register chosen by word address
  assign pready  = 1'b1;
  assign reg_idx = paddr[hds_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.conduction_gain <= hds_pkg::CONDUCTION_RESET;
      gains.source_gain     <= hds_pkg::SOURCE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        hds_pkg::REG_CONDUCTION: begin
          gains.conduction_gain <= pwdata[hds_pkg::GAIN_W-1:0];
        end
        hds_pkg::REG_SOURCE: begin
          gains.source_gain <= pwdata[hds_pkg::GAIN_W-1:0];
        end
        default: begin
          gains <= gains;
        end
      endcase
    end
  end

  // read back, gains zero extended to the bus width
  always_comb begin
    unique case (reg_idx)
      hds_pkg::REG_CONDUCTION: begin
        prdata = hds_pkg::DATA_W'(gains.conduction_gain);
      end
      hds_pkg::REG_SOURCE: begin
        prdata = hds_pkg::DATA_W'(gains.source_gain);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // front: counts raster position, keeps two line stores, builds the window
  hds_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .grid_cell(grid_cell),
    .full     (full),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  // decoupling queue, front reserves a slot before accepting a cell
  hds_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wdata  (q_data),
    .rd     (q_pop),
    .head   (q_head),
    .q_empty(q_empty),
    .count  (q_count)
  );

  // back: laplacian, gains, rounding, saturation, residual sum, result queue
  hds_back u_back (
    .clk    (clk),
    .rst    (rst),
    .gains  (gains),
    .q_head (q_head),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule

`default_nettype wire

// File: sv/hds_checker.sv
// port level checks for the heat diffusion stencil, bound to the top level
`default_nettype none

module hds_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             pop,
  input wire logic             empty,
  input wire hds_pkg::result_t result
);

  localparam logic [hds_pkg::CELL_IDX_W-1:0] LAST_IDX =
    hds_pkg::CELL_IDX_W'(hds_pkg::GRID_SIDE);

  // nothing waits right after reset
  assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting right after reset");

  // a waiting result holds until taken
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && (result == $past(result))))
    else $error("waiting result changed or vanished");

  // interior cells only
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((result.cell_row != '0) && (result.cell_column != '0)))
    else $error("border cell emitted");

  // end of sweep flag only on the last interior cell
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.sweep_done) |->
      ((result.cell_row == LAST_IDX) && (result.cell_column == LAST_IDX)))
    else $error("sweep end flagged on wrong cell");

endmodule

bind heat_diffusion_stencil_step hds_checker u_hds_checker (
  .clk   (clk),
  .rst   (rst),
  .pop   (pop),
  .empty (empty),
  .result(result)
);

`default_nettype wire

// File: tb/heat_diffusion_stencil_step_test.sv
// self-checking testbench for the five-point heat diffusion stencil: cell streams against a bit-true predictor
module heat_diffusion_stencil_step_test;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 4;
  localparam int ROW_LEN       = hds_pkg::ROW_LEN;
  // border cells may still be in flight in the pipeline after the last result
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 1_000_000;

  localparam logic [hds_pkg::TEMP_W-1:0] AMBIENT_TEMP = 32'd1258291200;  // 300 K in Q10.22
  localparam logic [hds_pkg::TEMP_W-1:0] HALF_SCALE   = 32'h8000_0000;
  localparam logic [hds_pkg::GAIN_W-1:0] GAIN_MAX     = '1;
  localparam longint DELTA_MAX = 64'sh7FFF_FFFF;
  localparam longint DELTA_MIN = -64'sh8000_0000;
  localparam longint TEMP_MAX  = 64'sh FFFF_FFFF;

  // dut signals, every input known from time zero
  logic                           clk     = 1'b0;
  logic                           rst     = 1'b1;
  logic                           push    = 1'b0;
  hds_pkg::cell_t                 offered_cell = '0;
  logic                           full;
  logic                           empty;
  logic                           pop     = 1'b0;
  hds_pkg::result_t               cell_update;
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [hds_pkg::ADDR_W-1:0]     paddr   = '0;
  logic [hds_pkg::DATA_W-1:0]     pwdata  = '0;
  logic [hds_pkg::DATA_W-1:0]     prdata;
  logic                           pready;

  // own copy of the line stores, raster counters, residual sum and gains
  logic [hds_pkg::TEMP_W-1:0]     upper_temps    [ROW_LEN];
  logic [hds_pkg::TEMP_W-1:0]     middle_temps   [ROW_LEN];
  logic [hds_pkg::SRC_W-1:0]      middle_sources [ROW_LEN];
  logic                           middle_holds   [ROW_LEN];
  int                             row_idx = 0;
  int                             col_idx = 0;
  logic [hds_pkg::RES_W-1:0]      residual_sum = '0;
  logic [hds_pkg::GAIN_W-1:0]     conduction_gain = hds_pkg::CONDUCTION_RESET;
  logic [hds_pkg::GAIN_W-1:0]     source_gain     = hds_pkg::SOURCE_RESET;

  // interior updates still owed by the block, oldest first
  hds_pkg::result_t               awaited_updates[$];

  // idling rates per side, and a one-shot receiver hold-off in cycles
  int                  push_idle_pct = 15;
  int                  pop_idle_pct  = 15;
  int                  hold_off_request = 0;

  int                  error_count   = 0;
  int                  cycle_count   = 0;
  int                  cells_sent    = 0;
  int                  updates_checked = 0;
  int                  sweeps_closed = 0;
  int                  held_centres  = 0;
  int                  stall_cycles  = 0;

  always #HALF_PERIOD clk = ~clk;

  // positional hookup, port order as declared by the block
  heat_diffusion_stencil_step i_dut (
    clk,           // clk
    rst,           // rst
    push,          // push
    offered_cell,  // cell request payload
    full,          // full
    empty,         // empty
    pop,           // pop
    cell_update,   // result payload
    psel,          // psel
    penable,       // penable
    pwrite,        // pwrite
    paddr,         // paddr
    pwdata,        // pwdata
    prdata,        // prdata
    pready         // pready
  );

  function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s expected 0x%0h got 0x%0h", name, want_v, got_v);
      error_count++;
    end
  endfunction

  // one raster step of the diffusion sweep: owed update for the centre above, then store shift
  function automatic void step_heat_sweep(hds_pkg::cell_t c);
    longint                     centre;
    longint                     lap;
    longint                     acc;
    longint                     delta;
    longint                     clipped;
    longint                     updated;
    longint unsigned            magnitude;
    logic [hds_pkg::RES_W:0]    total;
    hds_pkg::result_t           owed;
    // residual restarts with the first border cell of a sweep
    if (row_idx == 0 && col_idx == 0) residual_sum = '0;
    if (row_idx >= 2 && col_idx >= 1 && col_idx <= hds_pkg::GRID_SIDE) begin
      centre = longint'(middle_temps[col_idx]);
      // up, down, left (already shifted into the upper store), right, minus four centres
      lap = longint'(upper_temps[col_idx]) + longint'(c.cell_temperature)
          + longint'(upper_temps[col_idx-1]) + longint'(middle_temps[col_idx+1])
          - 4 * centre;
      // Q.46 sum: conduction term as is, source term lifted from Q.40
      acc = lap * longint'(conduction_gain)
          + ((longint'(source_gain) * longint'(middle_sources[col_idx])) <<< 6);
      // round half up to Q.22, arithmetic shift floors negatives
      delta = (acc + (longint'(1) <<< 23)) >>> 24;
      clipped = (delta > DELTA_MAX) ? DELTA_MAX : (delta < DELTA_MIN) ? DELTA_MIN : delta;
      if (middle_holds[col_idx]) begin
        updated = centre;
        held_centres++;
      end else begin
        updated = centre + delta;
        if (updated < 0) updated = 0;
        if (updated > TEMP_MAX) updated = TEMP_MAX;
      end
      // squared term from the saturated delta, sum sticks at all ones
      magnitude = (clipped < 0) ? -clipped : clipped;
      total = {1'b0, residual_sum} + (magnitude * magnitude);
      residual_sum = total[hds_pkg::RES_W] ? '1 : total[hds_pkg::RES_W-1:0];
      owed.new_temperature    = updated[hds_pkg::TEMP_W-1:0];
      owed.temperature_change = clipped[hds_pkg::TEMP_W-1:0];
      owed.cell_row           = hds_pkg::CELL_IDX_W'(row_idx - 1);
      owed.cell_column        = hds_pkg::CELL_IDX_W'(col_idx);
      owed.sweep_done         = (row_idx == hds_pkg::GRID_SIDE + 1
                                 && col_idx == hds_pkg::GRID_SIDE);
      owed.residual_squares   = residual_sum;
      awaited_updates.push_back(owed);
    end
    upper_temps[col_idx]    = middle_temps[col_idx];
    middle_temps[col_idx]   = c.cell_temperature;
    middle_sources[col_idx] = c.heat_source;
    middle_holds[col_idx]   = c.hold_cell;
    col_idx++;
    if (col_idx >= ROW_LEN) begin
      col_idx = 0;
      row_idx++;
      if (row_idx >= ROW_LEN) row_idx = 0;
    end
    cells_sent++;
  endfunction

  // smooth field around ambient, mostly sourceless, a few fixed cells
  function automatic hds_pkg::cell_t ambient_cell();
    hds_pkg::cell_t c;
    c.cell_temperature = AMBIENT_TEMP - (1 << 17) + $urandom_range(0, 1 << 18);
    c.heat_source      = ($urandom_range(99) < 10) ?
                         hds_pkg::SRC_W'($urandom_range(0, 1023)) : '0;
    c.hold_cell        = ($urandom_range(99) < 8);
    return c;
  endfunction

  // any value of any field
  function automatic hds_pkg::cell_t wild_cell();
    hds_pkg::cell_t c;
    c.cell_temperature = $urandom;
    c.heat_source      = hds_pkg::SRC_W'($urandom);
    c.hold_cell        = 1'($urandom_range(1));
    return c;
  endfunction

  // field extremes, to drive delta and temperature into saturation both ways
  function automatic hds_pkg::cell_t corner_cell();
    hds_pkg::cell_t c;
    case ($urandom_range(3))
      0:       c.cell_temperature = '0;
      1:       c.cell_temperature = '1;
      2:       c.cell_temperature = HALF_SCALE;
      default: c.cell_temperature = AMBIENT_TEMP;
    endcase
    c.heat_source = $urandom_range(1) ? '1 : '0;
    c.hold_cell   = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic logic [hds_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(3))
      0:       return '0;
      1:       return GAIN_MAX;
      default: return hds_pkg::GAIN_W'($urandom);
    endcase
  endfunction

  // offer one cell request, hold it until the block takes it; push stays high for the next call
  task automatic send_cell(input hds_pkg::cell_t c);
    while ($urandom_range(99) < push_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push         <= 1'b1;
    offered_cell <= c;
    do @(posedge clk); while (full);
    step_heat_sweep(c);
  endtask

  task automatic stream_cells(input int count, input int wild_pct);
    repeat (count) send_cell(($urandom_range(99) < wild_pct) ? wild_cell() : ambient_cell());
  endtask

  // stop offering, wait for every owed update, then let trailing border cells clear
  task automatic drain_block();
    @(negedge clk);
    push <= 1'b0;
    while (awaited_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic [hds_pkg::REG_IDX_W-1:0] idx,
                            input logic [hds_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      hds_pkg::REG_CONDUCTION: conduction_gain = value[hds_pkg::GAIN_W-1:0];
      hds_pkg::REG_SOURCE:     source_gain     = value[hds_pkg::GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_back_gain(input logic [hds_pkg::REG_IDX_W-1:0] idx);
    logic [hds_pkg::GAIN_W-1:0] held;
    held = (idx == hds_pkg::REG_CONDUCTION) ? conduction_gain : source_gain;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field((idx == hds_pkg::REG_CONDUCTION) ? "conduction_gain" : "source_gain",
                64'(held), 64'(prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper data bits carry junk, the registers keep only 24 bits
  task automatic set_gains(input logic [hds_pkg::GAIN_W-1:0] conduction,
                           input logic [hds_pkg::GAIN_W-1:0] source);
    write_gain(hds_pkg::REG_CONDUCTION,
               {(hds_pkg::DATA_W-hds_pkg::GAIN_W)'($urandom), conduction});
    write_gain(hds_pkg::REG_SOURCE,
               {(hds_pkg::DATA_W-hds_pkg::GAIN_W)'($urandom), source});
    read_back_gain(hds_pkg::REG_CONDUCTION);
    read_back_gain(hds_pkg::REG_SOURCE);
  endtask

  // reset values, then both extremes on each register
  task automatic test_register_access();
    read_back_gain(hds_pkg::REG_CONDUCTION);
    read_back_gain(hds_pkg::REG_SOURCE);
    set_gains(GAIN_MAX, '0);
    set_gains('0, GAIN_MAX);
    set_gains(hds_pkg::CONDUCTION_RESET, hds_pkg::SOURCE_RESET);
  endtask

  // opening rows of a sweep with a realistic field: held cells, residual sum from its start
  task automatic test_first_sweep();
    stream_cells(200, 0);
    drain_block();
    set_gains(hds_pkg::GAIN_W'($urandom), hds_pkg::GAIN_W'($urandom));
    // long stretch with no idling on either side
    push_idle_pct = 0;
    pop_idle_pct  = 0;
    stream_cells(200, 0);
    drain_block();
    push_idle_pct = 15;
    pop_idle_pct  = 15;
    set_gains('0, GAIN_MAX);
    stream_cells(150, 0);
    drain_block();
  endtask

  // field extremes under full gains, then a stretch with both gains off
  task automatic test_corner_values();
    set_gains(GAIN_MAX, GAIN_MAX);
    repeat (100) send_cell(corner_cell());
    drain_block();
    set_gains('0, '0);
    repeat (50) send_cell(corner_cell());
    drain_block();
  endtask

  // receiver holds off long enough for the block to fill and refuse cell requests
  task automatic test_backpressure();
    set_gains(hds_pkg::CONDUCTION_RESET, hds_pkg::SOURCE_RESET);
    push_idle_pct    = 0;
    hold_off_request = 400;
    stream_cells(200, 0);
    push_idle_pct    = 15;
    drain_block();
  endtask

  // mostly smooth fields with wild cells mixed in, fresh gains per phase
  task automatic test_random_cells();
    repeat (3) begin
      set_gains(pick_gain(), pick_gain());
      stream_cells(50, 30);
      drain_block();
    end
  endtask

  // receiver: random pops, or a counted hold-off when one is asked for
  initial begin : pop_results
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && hold_off_request > 0) begin
        stall_left       = hold_off_request;
        hold_off_request = 0;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= ($urandom_range(99) >= pop_idle_pct);
      end
    end
  end

  // every accepted result against the oldest owed update
  always @(posedge clk) begin : check_updates
    hds_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (awaited_updates.size() == 0) begin
        $error("update for row %0d column %0d with none owed",
               cell_update.cell_row, cell_update.cell_column);
        error_count++;
      end else begin
        want = awaited_updates.pop_front();
        check_field("new_temperature", want.new_temperature, cell_update.new_temperature);
        check_field("temperature_change", want.temperature_change,
                    cell_update.temperature_change);
        check_field("cell_row", want.cell_row, cell_update.cell_row);
        check_field("cell_column", want.cell_column, cell_update.cell_column);
        check_field("sweep_done", want.sweep_done, cell_update.sweep_done);
        check_field("residual_squares", want.residual_squares,
                    cell_update.residual_squares);
        updates_checked++;
        if (want.sweep_done) sweeps_closed++;
      end
    end
  end

  // watchdog, plus a count of refused cell requests
  always @(posedge clk) begin
    cycle_count++;
    if (push && full) stall_cycles++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped by the watchdog after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ROW_LEN; i++) begin
      upper_temps[i]    = '0;
      middle_temps[i]   = '0;
      middle_sources[i] = '0;
      middle_holds[i]   = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_access();
    test_first_sweep();
    test_corner_values();
    test_backpressure();
    test_random_cells();

    $display("%0d cells streamed, %0d interior updates checked, %0d held centres, %0d sweep ends",
             cells_sent, updates_checked, held_centres, sweeps_closed);
    $display("gain settings from zero to full scale; %0d cycles of refused cell requests",
             stall_cycles);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/hds_pkg.sv
sv/hds_ram.sv
sv/hds_front.sv
sv/hds_queue.sv
sv/hds_back.sv
sv/heat_diffusion_stencil_step.sv
sv/hds_checker.sv
tb/heat_diffusion_stencil_step_test.sv
